@@ rtl/core/rit_pkg.sv @@
// Shared types, constants and helpers for the reprojection inlier test.
package rit_pkg;

  localparam int ENTRY_W = 21;
  localparam int REG_W   = 63;
  localparam int THR_W   = 20;
  localparam int IDX_W   = 8;

  typedef enum logic [1:0] {
    CAUSE_INLIER   = 2'd0,
    CAUSE_TOO_FAR  = 2'd1,
    CAUSE_BEHIND   = 2'd2,
    CAUSE_ZERO_DEP = 2'd3
  } cause_t;

  localparam logic [IDX_W-1:0] REG_ROT0  = 8'd0;
  localparam logic [IDX_W-1:0] REG_ROT1  = 8'd1;
  localparam logic [IDX_W-1:0] REG_ROT2  = 8'd2;
  localparam logic [IDX_W-1:0] REG_TRANS = 8'd3;
  localparam logic [IDX_W-1:0] REG_CAM0  = 8'd4;
  localparam logic [IDX_W-1:0] REG_CAM1  = 8'd5;
  localparam logic [IDX_W-1:0] REG_CAM2  = 8'd6;
  localparam logic [IDX_W-1:0] REG_THR   = 8'd7;

  // Pull one signed entry out of a packed three-entry register.
  function automatic logic signed [ENTRY_W-1:0] entry(input logic [REG_W-1:0] r,
                                                      input logic [1:0] i);
    logic signed [ENTRY_W-1:0] e;
    unique case (i)
      2'd0:    e = r[20:0];
      2'd1:    e = r[41:21];
      default: e = r[62:42];
    endcase
    return e;
  endfunction

endpackage

@@ rtl/core/reprojection_inlier_test.sv @@
// Top level: pipelined pinhole reprojection inlier test.
// Takes one correspondence per cycle unless stalled and returns one verdict per item,
// in order, through 38 register stages. Stages: R*X products, camera-frame sum
// with the in-front test, K*Y products, projected sum with the zero-depth test,
// divider setup, thirty restoring divider stages (one quotient bit each, u and v
// side by side on a shared divisor), error terms, squares, and the compare that
// loads the output register. The whole pipeline advances together whenever the
// output register is empty or being taken, so a stall holds every item in place.
// Configuration is a write-only port that is always ready; write it only while
// no item is in flight. Out-of-range register indexes are ignored.
module reprojection_inlier_test (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [23:0]          point_x,
  input  logic signed [23:0]          point_y,
  input  logic signed [23:0]          point_z,
  input  logic signed [21:0]          pixel_u,
  input  logic signed [21:0]          pixel_v,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        inlier,
  output logic [1:0]                  reject_cause,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rit_pkg::IDX_W-1:0]   cfg_index,
  input  logic [63:0]                 cfg_data
);

  localparam int DSTEPS = 30;   // quotient bits: 22 integer + 8 fraction
  localparam int DW     = 88;   // remainder / shifted divisor width

  typedef struct packed {
    logic                valid;
    rit_pkg::cause_t     cause;
    logic signed [21:0]  pu;
    logic signed [21:0]  pv;
  } side_t;

  typedef struct packed {
    logic neg_u;
    logic neg_v;
    logic sat_u;
    logic sat_v;
  } dflag_t;

  // Configuration registers.
  logic [62:0] rot [3];
  logic [62:0] trans;
  logic [62:0] cam [3];
  logic [19:0] thr;

  logic en;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot[0] <= 63'd524288;
      rot[1] <= 63'd1099511627776;
      rot[2] <= 63'd2305843009213693952;
      trans  <= '0;
      cam[0] <= 63'd64;
      cam[1] <= 63'd134217728;
      cam[2] <= 63'd281474976710656;
      thr    <= 20'd512;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rit_pkg::REG_ROT0:  rot[0] <= cfg_data[62:0];
        rit_pkg::REG_ROT1:  rot[1] <= cfg_data[62:0];
        rit_pkg::REG_ROT2:  rot[2] <= cfg_data[62:0];
        rit_pkg::REG_TRANS: trans  <= cfg_data[62:0];
        rit_pkg::REG_CAM0:  cam[0] <= cfg_data[62:0];
        rit_pkg::REG_CAM1:  cam[1] <= cfg_data[62:0];
        rit_pkg::REG_CAM2:  cam[2] <= cfg_data[62:0];
        rit_pkg::REG_THR:   thr    <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // Stage 1: rotation products and translation entries.
  side_t s1;
  logic signed [44:0] p1 [3][3];
  logic signed [20:0] t1 [3];
  logic signed [23:0] xin [3];
  assign xin[0] = point_x;
  assign xin[1] = point_y;
  assign xin[2] = point_z;

  always_ff @(posedge clk) begin
    if (rst) s1.valid <= 1'b0;
    else if (en) s1.valid <= in_valid;
    if (en) begin
      s1.cause <= rit_pkg::CAUSE_INLIER;
      s1.pu    <= pixel_u;
      s1.pv    <= pixel_v;
      for (int i = 0; i < 3; i++) begin
        t1[i] <= rit_pkg::entry(trans, 2'(i));
        for (int j = 0; j < 3; j++)
          p1[i][j] <= rit_pkg::entry(rot[i], 2'(j)) * xin[j];
      end
    end
  end

  // Stage 2: camera-frame point in Q.31; reject when not in front.
  side_t s2;
  logic signed [46:0] y2 [3];
  logic signed [46:0] y_sum [3];
  always_comb begin
    for (int i = 0; i < 3; i++)
      y_sum[i] = {{5{t1[i][20]}}, t1[i], 21'd0}
               + 47'(p1[i][0]) + 47'(p1[i][1]) + 47'(p1[i][2]);
  end

  always_ff @(posedge clk) begin
    if (rst) s2.valid <= 1'b0;
    else if (en) s2.valid <= s1.valid;
    if (en) begin
      s2.pu    <= s1.pu;
      s2.pv    <= s1.pv;
      s2.cause <= (y_sum[2][46] || y_sum[2] == '0) ? rit_pkg::CAUSE_BEHIND
                                                   : rit_pkg::CAUSE_INLIER;
      for (int i = 0; i < 3; i++) y2[i] <= y_sum[i];
    end
  end

  // Stage 3: drop to Q.20 (floor) and form camera matrix products.
  side_t s3;
  logic signed [56:0] p3 [3][3];
  logic signed [35:0] ysh [3];
  always_comb begin
    for (int i = 0; i < 3; i++) ysh[i] = y2[i][46:11];
  end

  always_ff @(posedge clk) begin
    if (rst) s3.valid <= 1'b0;
    else if (en) s3.valid <= s2.valid;
    if (en) begin
      s3.pu    <= s2.pu;
      s3.pv    <= s2.pv;
      s3.cause <= s2.cause;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          p3[i][j] <= rit_pkg::entry(cam[i], 2'(j)) * ysh[j];
    end
  end

  // Stage 4: projected point in Q.26; reject a zero projected depth.
  side_t s4;
  logic signed [58:0] pp [3];
  logic signed [58:0] p_sum [3];
  always_comb begin
    for (int i = 0; i < 3; i++)
      p_sum[i] = 59'(p3[i][0]) + 59'(p3[i][1]) + 59'(p3[i][2]);
  end

  always_ff @(posedge clk) begin
    if (rst) s4.valid <= 1'b0;
    else if (en) s4.valid <= s3.valid;
    if (en) begin
      s4.pu <= s3.pu;
      s4.pv <= s3.pv;
      if (s3.cause == rit_pkg::CAUSE_INLIER && p_sum[2] == '0)
        s4.cause <= rit_pkg::CAUSE_ZERO_DEP;
      else
        s4.cause <= s3.cause;
      for (int i = 0; i < 3; i++) pp[i] <= p_sum[i];
    end
  end

  // Stage 5 (divider slot 0): magnitudes, signs, saturation, initial remainders.
  side_t           ds   [DSTEPS+1];
  dflag_t          df   [DSTEPS+1];
  logic [DW-1:0]   dden [DSTEPS+1];
  logic [DW-1:0]   drem_u [DSTEPS+1];
  logic [DW-1:0]   drem_v [DSTEPS+1];
  logic [DSTEPS-1:0] dq_u [DSTEPS+1];
  logic [DSTEPS-1:0] dq_v [DSTEPS+1];

  logic [58:0] mag_x, mag_y, mag_z;
  logic [79:0] den_sat;
  always_comb begin
    mag_x   = pp[0][58] ? 59'(-pp[0]) : pp[0];
    mag_y   = pp[1][58] ? 59'(-pp[1]) : pp[1];
    mag_z   = pp[2][58] ? 59'(-pp[2]) : pp[2];
    den_sat = {mag_z[57:0], 22'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) ds[0].valid <= 1'b0;
    else if (en) ds[0].valid <= s4.valid;
    if (en) begin
      ds[0].pu    <= s4.pu;
      ds[0].pv    <= s4.pv;
      ds[0].cause <= s4.cause;
      df[0].neg_u <= pp[0][58] ^ pp[2][58];
      df[0].neg_v <= pp[1][58] ^ pp[2][58];
      df[0].sat_u <= {22'd0, mag_x[57:0]} >= den_sat;
      df[0].sat_v <= {22'd0, mag_y[57:0]} >= den_sat;
      dden[0]     <= DW'(mag_z[57:0]);
      drem_u[0]   <= DW'({mag_x[57:0], 8'd0});
      drem_v[0]   <= DW'({mag_y[57:0], 8'd0});
      dq_u[0]     <= '0;
      dq_v[0]     <= '0;
    end
  end

  // Restoring divider: slot s resolves quotient bit DSTEPS-s.
  for (genvar s = 1; s <= DSTEPS; s++) begin : g_div
    logic [DW-1:0] dsh;
    logic          ge_u, ge_v;
    assign dsh  = dden[s-1] << (DSTEPS - s);
    assign ge_u = drem_u[s-1] >= dsh;
    assign ge_v = drem_v[s-1] >= dsh;

    always_ff @(posedge clk) begin
      if (rst) ds[s].valid <= 1'b0;
      else if (en) ds[s].valid <= ds[s-1].valid;
      if (en) begin
        ds[s].pu    <= ds[s-1].pu;
        ds[s].pv    <= ds[s-1].pv;
        ds[s].cause <= ds[s-1].cause;
        df[s]       <= df[s-1];
        dden[s]     <= dden[s-1];
        drem_u[s]   <= ge_u ? drem_u[s-1] - dsh : drem_u[s-1];
        drem_v[s]   <= ge_v ? drem_v[s-1] - dsh : drem_v[s-1];
        dq_u[s]     <= dq_u[s-1] | (DSTEPS'(ge_u) << (DSTEPS - s));
        dq_v[s]     <= dq_v[s-1] | (DSTEPS'(ge_v) << (DSTEPS - s));
      end
    end
  end

  // Error terms in Q.8.
  side_t s6;
  logic signed [32:0] eu6, ev6;
  logic [31:0] qu_mag, qv_mag;
  logic signed [31:0] proj_u, proj_v;
  always_comb begin
    qu_mag = df[DSTEPS].sat_u ? 32'h4000_0000 : 32'(dq_u[DSTEPS]);
    qv_mag = df[DSTEPS].sat_v ? 32'h4000_0000 : 32'(dq_v[DSTEPS]);
    proj_u = df[DSTEPS].neg_u ? -$signed(qu_mag) : $signed(qu_mag);
    proj_v = df[DSTEPS].neg_v ? -$signed(qv_mag) : $signed(qv_mag);
  end

  always_ff @(posedge clk) begin
    if (rst) s6.valid <= 1'b0;
    else if (en) s6.valid <= ds[DSTEPS].valid;
    if (en) begin
      s6.cause <= ds[DSTEPS].cause;
      s6.pu    <= ds[DSTEPS].pu;
      s6.pv    <= ds[DSTEPS].pv;
      eu6      <= 33'(ds[DSTEPS].pu) - 33'(proj_u);
      ev6      <= 33'(ds[DSTEPS].pv) - 33'(proj_v);
    end
  end

  // Squares of the error terms and of the threshold.
  side_t s7;
  logic [65:0] equ7, eqv7;
  logic [39:0] th2;
  always_ff @(posedge clk) begin
    if (rst) s7.valid <= 1'b0;
    else if (en) s7.valid <= s6.valid;
    if (en) begin
      s7.cause <= s6.cause;
      s7.pu    <= s6.pu;
      s7.pv    <= s6.pv;
      equ7     <= 66'(eu6 * eu6);
      eqv7     <= 66'(ev6 * ev6);
      th2      <= thr * thr;
    end
  end

  // Final compare; load the output register.
  logic [66:0] err2;
  assign err2 = 67'(equ7) + 67'(eqv7);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= s7.valid;
    if (en) begin
      if (s7.cause != rit_pkg::CAUSE_INLIER) begin
        inlier       <= 1'b0;
        reject_cause <= s7.cause;
      end else if (err2 < 67'(th2)) begin
        inlier       <= 1'b1;
        reject_cause <= rit_pkg::CAUSE_INLIER;
      end else begin
        inlier       <= 1'b0;
        reject_cause <= rit_pkg::CAUSE_TOO_FAR;
      end
    end
  end

`ifndef SYNTHESIS
  a_flag_matches_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (inlier == (reject_cause == rit_pkg::CAUSE_INLIER)))
    else $error("inlier flag disagrees with reject cause");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(reject_cause)))
    else $error("stalled result changed");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while pipeline is stalled");
`endif

endmodule
